// ===== rtl/dspp_pkg.sv =====
// ----------------------------------------------------------------------------
// dspp_pkg
// Types and constants shared by the depth-scaled patch placer files.
// ----------------------------------------------------------------------------
package dspp_pkg;

  localparam int unsigned MAX_COLS    = 1024;
  localparam int unsigned MAX_ROWS    = 1024;
  localparam int unsigned NUM_PATCHES = 4;

  // divider passes: one overflow bit plus 11 size bits
  localparam int unsigned DIV_STEPS   = 12;

  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LIMITS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATCH_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATCH_0      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PATCH_1      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PATCH_2      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PATCH_3      = 3'd6;

  // patch template register layout, MSB first
  typedef struct packed {
    logic signed [9:0] prop_y;
    logic signed [9:0] prop_x;
    logic [9:0]        min_h;
    logic [9:0]        min_w;
    logic [11:0]       real_h;
    logic [11:0]       real_w;
  } patch_t;

  typedef struct packed {
    logic [1:0]  patch_index;
    logic [9:0]  anchor_x;
    logic [9:0]  anchor_y;
    logic [9:0]  rect_x;
    logic [9:0]  rect_y;
    logic [10:0] rect_width;
    logic [10:0] rect_height;
    logic        last;
  } out_item_t;

endpackage

// ===== rtl/dspp_if.sv =====
// ----------------------------------------------------------------------------
// dspp channel interfaces
// Valid/ready channels for depth samples, placements and register writes.
// ----------------------------------------------------------------------------
interface dspp_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] depth;

  modport source (output valid, output depth, input ready);
  modport sink   (input valid, input depth, output ready);
endinterface

interface dspp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  patch_index;
  logic [9:0]  anchor_x;
  logic [9:0]  anchor_y;
  logic [9:0]  rect_x;
  logic [9:0]  rect_y;
  logic [10:0] rect_width;
  logic [10:0] rect_height;
  logic        last;

  modport source (output valid, output patch_index, output anchor_x, output anchor_y,
                  output rect_x, output rect_y, output rect_width, output rect_height,
                  output last, input ready);
  modport sink   (input valid, input patch_index, input anchor_x, input anchor_y,
                  input rect_x, input rect_y, input rect_width, input rect_height,
                  input last, output ready);
endinterface

interface dspp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [dspp_pkg::CFG_IDX_W-1:0]  index;
  logic [dspp_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/depth_scaled_patch_placer.sv =====
// ----------------------------------------------------------------------------
// depth_scaled_patch_placer
// Places up to four depth-scaled patch rectangles around each range pixel.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                  | accepted when
//  in_i    | in  | depth                                    | valid & ready
//  out_o   | out | patch_index, anchor, rect, width, height | valid & ready
//  cfg_i   | in  | index, data                              | valid & ready
//
// A rejected depth (zero, out of range, or no templates) is dropped in the
// accept state. Otherwise each template that reaches placement runs two
// passes of the shared multiplier and the restoring divider, for width and
// height, then a size check, two offset multiplies and placement; one that
// fails the size check is dropped there. A flush state then releases the
// held placement. The sequencer takes a new depth only after the flush.
// Reset is asynchronous, active low; no clearing pass. A stalled output
// holds the sequencer only when the held placement has to move into a
// still-full output register.
// ----------------------------------------------------------------------------
module depth_scaled_patch_placer (
  input  logic              clk_i,
  input  logic              rst_ni,
  dspp_in_if.sink           in_i,
  dspp_out_if.source        out_o,
  dspp_cfg_if.sink          cfg_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_SIZE  = 3'd3;
  localparam logic [2:0] S_OFFX  = 3'd4;
  localparam logic [2:0] S_OFFY  = 3'd5;
  localparam logic [2:0] S_PLACE = 3'd6;
  localparam logic [2:0] S_FLUSH = 3'd7;

  // configuration
  logic [31:0]            range_q;
  logic [21:0]            image_q;
  logic [2:0]             pcount_q;
  dspp_pkg::patch_t       patch_q [dspp_pkg::NUM_PATCHES];

  // control
  logic [2:0]  state_q, state_d;
  logic [1:0]  p_q, p_d;
  logic        dim_q, dim_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [2:0]  npat_q, npat_d;
  logic [9:0]  col_q, col_d;
  logic [9:0]  row_q, row_d;
  logic        pend_v_q, pend_v_d;
  logic        out_v_q, out_v_d;

  // datapath
  logic [15:0] depth_q, depth_d;
  logic [9:0]  ax_q, ax_d;
  logic [9:0]  ay_q, ay_d;
  logic [22:0] rem_q, rem_d;
  logic [27:0] dsh_q, dsh_d;
  logic [11:0] quo_q, quo_d;
  logic [10:0] w_q, w_d;
  logic [10:0] h_q, h_d;
  logic [14:0] rx_q, rx_d;
  logic [14:0] ry_q, ry_d;
  dspp_pkg::out_item_t pend_q, pend_d;
  dspp_pkg::out_item_t out_q, out_d;

  // derived image geometry
  logic [10:0] img_c, img_r, cols, rows;
  logic [15:0] dmin, dmax;
  logic [2:0]  npat_in;
  logic        depth_ok;

  assign img_c = image_q[10:0];
  assign img_r = image_q[21:11];
  assign cols  = (img_c == 11'd0) ? 11'd1 :
                 (img_c > 11'(dspp_pkg::MAX_COLS)) ? 11'(dspp_pkg::MAX_COLS) : img_c;
  assign rows  = (img_r == 11'd0) ? 11'd1 :
                 (img_r > 11'(dspp_pkg::MAX_ROWS)) ? 11'(dspp_pkg::MAX_ROWS) : img_r;
  assign dmin  = range_q[15:0];
  assign dmax  = range_q[31:16];
  assign npat_in = (pcount_q > 3'(dspp_pkg::NUM_PATCHES)) ?
                   3'(dspp_pkg::NUM_PATCHES) : pcount_q;
  assign depth_ok = (in_i.depth != 16'd0) && (in_i.depth >= dmin) && (in_i.depth <= dmax);

  dspp_pkg::patch_t pat;
  assign pat = patch_q[p_q];

  // shared signed multiplier
  logic signed [12:0] mul_a, mul_b;
  logic signed [25:0] prod;

  always_comb begin
    case (state_q)
      S_OFFX: begin
        mul_a = {{3{pat.prop_x[9]}}, pat.prop_x};
        mul_b = {2'b00, w_q};
      end
      S_OFFY: begin
        mul_a = {{3{pat.prop_y[9]}}, pat.prop_y};
        mul_b = {2'b00, h_q};
      end
      default: begin
        mul_a = dim_q ? {3'b000, rows[10:1]} : {3'b000, cols[10:1]};
        mul_b = dim_q ? {1'b0, pat.real_h} : {1'b0, pat.real_w};
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // size numerator 2*half*real + depth, divisor 2*depth aligned to bit 11
  logic [22:0] num_full;
  logic [27:0] den_sh;
  assign num_full = {1'b0, prod[20:0], 1'b0} + {7'b0, depth_q};
  assign den_sh   = {depth_q, 12'b0};

  // one restoring divider step
  logic        div_ge;
  logic [11:0] quo_nx;
  logic [10:0] size_res;
  assign div_ge   = {5'b0, rem_q} >= dsh_q;
  assign quo_nx   = {quo_q[10:0], div_ge};
  // quotient bit 11 set means the size is far beyond any image
  assign size_res = quo_nx[11] ? 11'h7FF : quo_nx[10:0];

  // rounded offset, floor((prop*size + 128) / 256)
  logic signed [25:0] off_full;
  logic [13:0]        off;
  logic [14:0]        anchor_sel;
  logic [14:0]        rect_new;
  assign off_full   = prod + 26'sd128;
  assign off        = off_full[21:8];
  assign anchor_sel = (state_q == S_OFFY) ? {5'b0, ay_q} : {5'b0, ax_q};
  assign rect_new   = anchor_sel - {off[13], off};

  logic size_bad, fits, last_tpl, out_free;
  logic [14:0] x_end, y_end;
  assign size_bad = (w_q < {1'b0, pat.min_w}) || (h_q < {1'b0, pat.min_h}) ||
                    (w_q == 11'd0) || (h_q == 11'd0) || (w_q > cols) || (h_q > rows);
  assign x_end    = {1'b0, rx_q[13:0]} + {4'b0, w_q};
  assign y_end    = {1'b0, ry_q[13:0]} + {4'b0, h_q};
  assign fits     = !rx_q[14] && !ry_q[14] &&
                    (x_end <= {4'b0, cols}) && (y_end <= {4'b0, rows});
  assign last_tpl = ({1'b0, p_q} + 3'd1) >= npat_q;
  assign out_free = !out_v_q || out_o.ready;

  dspp_pkg::out_item_t cand;
  always_comb begin
    cand.patch_index = p_q;
    cand.anchor_x    = ax_q;
    cand.anchor_y    = ay_q;
    cand.rect_x      = rx_q[9:0];
    cand.rect_y      = ry_q[9:0];
    cand.rect_width  = w_q;
    cand.rect_height = h_q;
    cand.last        = 1'b0;
  end

  logic in_acc;
  assign in_acc = in_i.valid && (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    p_d      = p_q;
    dim_d    = dim_q;
    cnt_d    = cnt_q;
    npat_d   = npat_q;
    col_d    = col_q;
    row_d    = row_q;
    pend_v_d = pend_v_q;
    out_v_d  = out_o.ready ? 1'b0 : out_v_q;
    depth_d  = depth_q;
    ax_d     = ax_q;
    ay_d     = ay_q;
    rem_d    = rem_q;
    dsh_d    = dsh_q;
    quo_d    = quo_q;
    w_d      = w_q;
    h_d      = h_q;
    rx_d     = rx_q;
    ry_d     = ry_q;
    pend_d   = pend_q;
    out_d    = out_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          depth_d = in_i.depth;
          ax_d    = col_q;
          ay_d    = row_q;
          npat_d  = npat_in;
          p_d     = 2'd0;
          dim_d   = 1'b0;
          if (({1'b0, col_q} + 11'd1) >= cols) begin
            col_d = 10'd0;
            row_d = (({1'b0, row_q} + 11'd1) >= rows) ? 10'd0 : row_q + 10'd1;
          end else begin
            col_d = col_q + 10'd1;
          end
          if (depth_ok && (npat_in != 3'd0)) begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        rem_d   = num_full;
        dsh_d   = den_sh;
        quo_d   = 12'd0;
        cnt_d   = 4'(dspp_pkg::DIV_STEPS - 1);
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_ge) begin
          rem_d = rem_q - dsh_q[22:0];
        end
        quo_d = quo_nx;
        dsh_d = {1'b0, dsh_q[27:1]};
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          if (!dim_q) begin
            w_d     = size_res;
            dim_d   = 1'b1;
            state_d = S_MUL;
          end else begin
            h_d     = size_res;
            state_d = S_SIZE;
          end
        end
      end
      S_SIZE: begin
        if (size_bad) begin
          if (last_tpl) begin
            state_d = S_FLUSH;
          end else begin
            p_d     = p_q + 2'd1;
            dim_d   = 1'b0;
            state_d = S_MUL;
          end
        end else begin
          state_d = S_OFFX;
        end
      end
      S_OFFX: begin
        rx_d    = rect_new;
        state_d = S_OFFY;
      end
      S_OFFY: begin
        ry_d    = rect_new;
        state_d = S_PLACE;
      end
      S_PLACE: begin
        if (!fits || !pend_v_q || out_free) begin
          if (fits) begin
            // the held placement is not the pixel's final one
            if (pend_v_q) begin
              out_d      = pend_q;
              out_d.last = 1'b0;
              out_v_d    = 1'b1;
            end
            pend_d   = cand;
            pend_v_d = 1'b1;
          end
          if (last_tpl) begin
            state_d = S_FLUSH;
          end else begin
            p_d     = p_q + 2'd1;
            dim_d   = 1'b0;
            state_d = S_MUL;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_v_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_d      = pend_q;
          out_d.last = 1'b1;
          out_v_d    = 1'b1;
          pend_v_d   = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      p_q      <= 2'd0;
      dim_q    <= 1'b0;
      cnt_q    <= 4'd0;
      npat_q   <= 3'd0;
      col_q    <= 10'd0;
      row_q    <= 10'd0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      range_q  <= 32'd0;
      image_q  <= 22'd0;
      pcount_q <= 3'd0;
      for (int i = 0; i < dspp_pkg::NUM_PATCHES; i++) begin
        patch_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      p_q      <= p_d;
      dim_q    <= dim_d;
      cnt_q    <= cnt_d;
      npat_q   <= npat_d;
      col_q    <= col_d;
      row_q    <= row_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          dspp_pkg::CFG_RANGE_LIMITS: range_q    <= cfg_i.data[31:0];
          dspp_pkg::CFG_IMAGE_SIZE:   image_q    <= cfg_i.data[21:0];
          dspp_pkg::CFG_PATCH_COUNT:  pcount_q   <= cfg_i.data[2:0];
          dspp_pkg::CFG_PATCH_0:      patch_q[0] <= cfg_i.data;
          dspp_pkg::CFG_PATCH_1:      patch_q[1] <= cfg_i.data;
          dspp_pkg::CFG_PATCH_2:      patch_q[2] <= cfg_i.data;
          dspp_pkg::CFG_PATCH_3:      patch_q[3] <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    depth_q <= depth_d;
    ax_q    <= ax_d;
    ay_q    <= ay_d;
    rem_q   <= rem_d;
    dsh_q   <= dsh_d;
    quo_q   <= quo_d;
    w_q     <= w_d;
    h_q     <= h_d;
    rx_q    <= rx_d;
    ry_q    <= ry_d;
    pend_q  <= pend_d;
    out_q   <= out_d;
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign out_o.valid       = out_v_q;
  assign out_o.patch_index = out_q.patch_index;
  assign out_o.anchor_x    = out_q.anchor_x;
  assign out_o.anchor_y    = out_q.anchor_y;
  assign out_o.rect_x      = out_q.rect_x;
  assign out_o.rect_y      = out_q.rect_y;
  assign out_o.rect_width  = out_q.rect_width;
  assign out_o.rect_height = out_q.rect_height;
  assign out_o.last        = out_q.last;

endmodule

// ===== rtl/dspp_checker.sv =====
// ----------------------------------------------------------------------------
// dspp_checker
// Port-level checks for the depth-scaled patch placer, bound to the top level.
// ----------------------------------------------------------------------------
module dspp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_last_i,
  input logic [1:0]  out_patch_index_i,
  input logic [10:0] out_rect_width_i
);

  // stalled output item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_patch_index_i) &&
                                    $stable(out_rect_width_i) && $stable(out_last_i))
    else $error("output item changed while stalled");

  // the sequencer only leaves idle on an accepted item
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> $past(in_valid_i && in_ready_i))
    else $error("input ready dropped without an accepted item");

  // a non-final placement means the pixel is still being worked on
  a_not_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("idle while a pixel's placements are incomplete");

  // a new result is only produced while the sequencer is busy
  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared from an idle sequencer");

endmodule

bind depth_scaled_patch_placer dspp_checker u_dspp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_last_i        (out_o.last),
  .out_patch_index_i (out_o.patch_index),
  .out_rect_width_i  (out_o.rect_width)
);

// ===== verif/placement_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// placement_checker
// Watches the register, depth and placement channels of the patch placer.
// It keeps its own copy of the registers and pixel counters, works out the
// placements each accepted depth should cause, and compares every placement
// that leaves the block, field by field, against the oldest one still due.
// ----------------------------------------------------------------------------
module placement_checker
  import dspp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  dspp_in_if          in_mon,
  dspp_out_if         out_mon,
  dspp_cfg_if         cfg_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned placements_o,
  output int unsigned samples_o
);

  logic [31:0] range_lim = '0;
  logic [21:0] img_size  = '0;
  logic [2:0]  tpl_count = '0;
  patch_t      tpl [NUM_PATCHES];
  int unsigned col_pos;
  int unsigned row_pos;
  out_item_t   due_placements[$];
  out_item_t   got;
  out_item_t   want;
  int unsigned mismatches;
  int unsigned placements;
  int unsigned samples;

  function automatic int unsigned clamp_dim(input logic [10:0] v, input int unsigned maxv);
    if (v == '0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic void predict_placements(input logic [15:0] depth);
    int unsigned cols;
    int unsigned rows;
    int unsigned npat;
    int          p;
    longint      w, h, off_x, off_y, rx, ry;
    out_item_t   item;
    out_item_t   found[$];
    cols = clamp_dim(img_size[10:0], MAX_COLS);
    rows = clamp_dim(img_size[21:11], MAX_ROWS);
    npat = (tpl_count > NUM_PATCHES) ? NUM_PATCHES : tpl_count;
    if (depth != '0 && depth >= range_lim[15:0] && depth <= range_lim[31:16]) begin
      for (p = 0; p < npat; p++) begin
        // round(half dim * real / depth), half up
        w = (2 * longint'(cols / 2) * longint'(tpl[p].real_w) + longint'(depth))
            / (2 * longint'(depth));
        h = (2 * longint'(rows / 2) * longint'(tpl[p].real_h) + longint'(depth))
            / (2 * longint'(depth));
        if (w < longint'(tpl[p].min_w) || h < longint'(tpl[p].min_h)) continue;
        if (w == 0 || h == 0 || w > longint'(cols) || h > longint'(rows)) continue;
        // arithmetic shift gives floor, so negative offsets round half up too
        off_x = (longint'($signed(tpl[p].prop_x)) * w + 128) >>> 8;
        off_y = (longint'($signed(tpl[p].prop_y)) * h + 128) >>> 8;
        rx = longint'(col_pos) - off_x;
        ry = longint'(row_pos) - off_y;
        if (rx < 0 || ry < 0) continue;
        if (rx + w > longint'(cols) || ry + h > longint'(rows)) continue;
        item.patch_index = 2'(p);
        item.anchor_x    = 10'(col_pos);
        item.anchor_y    = 10'(row_pos);
        item.rect_x      = 10'(rx);
        item.rect_y      = 10'(ry);
        item.rect_width  = 11'(w);
        item.rect_height = 11'(h);
        item.last        = 1'b0;
        found.insert(found.size(), item);
      end
      if (found.size() > 0) found[found.size() - 1].last = 1'b1;
      foreach (found[i]) due_placements.insert(due_placements.size(), found[i]);
    end
    // counters wrap at the current size, also when already past it
    if (col_pos + 1 >= cols) begin
      col_pos = 0;
      if (row_pos + 1 >= rows) row_pos = 0;
      else row_pos = row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_lim  = '0;
      img_size   = '0;
      tpl_count  = '0;
      foreach (tpl[i]) tpl[i] = '0;
      col_pos    = 0;
      row_pos    = 0;
      mismatches = 0;
      placements = 0;
      samples    = 0;
      due_placements.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      placements_o <= 0;
      samples_o    <= 0;
    end else begin
      // a placement can never come from a sample taken at the same edge
      if (out_mon.valid && out_mon.ready) begin
        got.patch_index = out_mon.patch_index;
        got.anchor_x    = out_mon.anchor_x;
        got.anchor_y    = out_mon.anchor_y;
        got.rect_x      = out_mon.rect_x;
        got.rect_y      = out_mon.rect_y;
        got.rect_width  = out_mon.rect_width;
        got.rect_height = out_mon.rect_height;
        got.last        = out_mon.last;
        placements++;
        if (due_placements.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected placement idx %0d anchor (%0d,%0d) rect (%0d,%0d) %0dx%0d",
                     $time, got.patch_index, got.anchor_x, got.anchor_y, got.rect_x,
                     got.rect_y, got.rect_width, got.rect_height);
        end else begin
          want = due_placements.pop_front();
          if (got.patch_index !== want.patch_index || got.anchor_x !== want.anchor_x ||
              got.anchor_y !== want.anchor_y || got.rect_x !== want.rect_x ||
              got.rect_y !== want.rect_y || got.rect_width !== want.rect_width ||
              got.rect_height !== want.rect_height || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: placement mismatch, expected idx %0d anchor (%0d,%0d) rect (%0d,%0d) %0dx%0d last %0d",
                       $time, want.patch_index, want.anchor_x, want.anchor_y, want.rect_x,
                       want.rect_y, want.rect_width, want.rect_height, want.last);
              $display("    actual idx %0d anchor (%0d,%0d) rect (%0d,%0d) %0dx%0d last %0d",
                       got.patch_index, got.anchor_x, got.anchor_y, got.rect_x,
                       got.rect_y, got.rect_width, got.rect_height, got.last);
            end
          end
        end
      end

      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_RANGE_LIMITS: range_lim = cfg_mon.data[31:0];
          CFG_IMAGE_SIZE:   img_size  = cfg_mon.data[21:0];
          CFG_PATCH_COUNT:  tpl_count = cfg_mon.data[2:0];
          CFG_PATCH_0:      tpl[0]    = cfg_mon.data;
          CFG_PATCH_1:      tpl[1]    = cfg_mon.data;
          CFG_PATCH_2:      tpl[2]    = cfg_mon.data;
          CFG_PATCH_3:      tpl[3]    = cfg_mon.data;
          default: ;
        endcase
      end

      if (in_mon.valid && in_mon.ready) begin
        samples++;
        predict_placements(in_mon.depth);
      end

      fail_count_o <= mismatches;
      pending_o    <= due_placements.size();
      placements_o <= placements;
      samples_o    <= samples;
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Test bench for the depth-scaled patch placer. Loads a series of register
// setups (directed corner cases first, then random ones), streams depth
// samples in bursts while the output side stalls on its own pattern, and
// leaves all result checking to placement_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import dspp_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 130;   // worst-case item latency plus margin
  localparam int unsigned HOLD_CYCLES    = 600;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned TOTAL_ITEMS    = 160;
  localparam int unsigned MAX_SETUPS     = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        long_hold = 1'b0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned placements;
  int unsigned samples;
  int unsigned idle_cycles = 0;
  int unsigned setups = 0;
  logic [15:0] depth_q[$];

  dspp_in_if  in_if ();
  dspp_out_if out_if ();
  dspp_cfg_if cfg_if ();

  depth_scaled_patch_placer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  placement_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .cfg_mon      (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .placements_o (placements),
    .samples_o    (samples)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] make_patch(input int unsigned real_w, real_h, min_w, min_h,
                                             input int prop_x, prop_y);
    patch_t tpl;
    tpl.real_w = 12'(real_w);
    tpl.real_h = 12'(real_h);
    tpl.min_w  = 10'(min_w);
    tpl.min_h  = 10'(min_h);
    tpl.prop_x = 10'(prop_x);
    tpl.prop_y = 10'(prop_y);
    return tpl;
  endfunction

  function automatic logic [21:0] make_size(input int unsigned cols, rows);
    return {11'(rows), 11'(cols)};
  endfunction

  // mostly pulls the rectangle right/down of the anchor, sometimes anything
  function automatic int rand_prop();
    if ($urandom_range(0, 5) == 0) return int'($urandom_range(0, 1023)) - 512;
    return int'($urandom_range(0, 500)) - 300;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop offering, wait for every due placement, then cover a result-less item
  task automatic settle();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_setup(input logic [31:0] range_word, input logic [21:0] img,
                            input logic [2:0] count,
                            input logic [63:0] t0, t1, t2, t3);
    settle();
    write_reg(CFG_RANGE_LIMITS, 64'(range_word));
    write_reg(CFG_IMAGE_SIZE, 64'(img));
    write_reg(CFG_PATCH_COUNT, 64'(count));
    write_reg(CFG_PATCH_0, t0);
    write_reg(CFG_PATCH_1, t1);
    write_reg(CFG_PATCH_2, t2);
    write_reg(CFG_PATCH_3, t3);
    setups++;
  endtask

  // leaves valid up after the last item; the following settle drops it
  task automatic play_depths();
    int unsigned burst;
    int unsigned gap;
    bit          no_gaps;
    no_gaps = ($urandom_range(0, 3) == 0);
    burst   = $urandom_range(1, 12);
    while (depth_q.size() > 0) begin
      in_if.valid <= 1'b1;
      in_if.depth <= depth_q.pop_front();
      do @(posedge clk_i); while (!in_if.ready);
      burst--;
      if (burst == 0 && depth_q.size() > 0) begin
        burst = $urandom_range(1, 12);
        gap   = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        if (gap > 0) begin
          in_if.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  endtask

  // output side: a rotating set of four stall patterns, one long hold
  initial begin
    int unsigned tick;
    bit          held;
    tick = 0;
    held = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold && !held) begin
        held = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      case (tick[9:8])
        2'd0:    out_if.ready <= 1'b1;
        2'd1:    out_if.ready <= ($urandom_range(0, 1) == 1);
        2'd2:    out_if.ready <= (tick[2:0] == 3'd0);
        default: out_if.ready <= ($urandom_range(0, 4) != 0);
      endcase
      tick++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer on any channel for %0d cycles", idle_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int unsigned cols;
    int unsigned rows;
    int unsigned count;
    int unsigned n;
    int unsigned r;
    int unsigned t;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [31:0] range_word;
    logic [63:0] tpls [NUM_PATCHES];
    logic [15:0] d;
    bit          hold_done;

    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.depth  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data  = '0;
    hold_done    = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: range 0..0 turns every sample away
    depth_q = {16'd0, 16'hFFFF};
    play_depths();

    // range boundaries, zero depth, extreme offset proportions
    load_setup({16'd4000, 16'd200}, make_size(64, 48), 3'd4,
               make_patch(300, 300, 0, 0, -128, -128),
               make_patch(600, 200, 4, 4, 0, 0),
               make_patch(150, 150, 0, 0, -512, -512),
               make_patch(100, 400, 10, 10, 511, 511));
    depth_q = {16'd0, 16'd199, 16'd200, 16'd4000, 16'd4001, 16'd1000, 16'd700,
               16'd2500, 16'hFFFF};
    play_depths();

    // all-ones range, zero image size, count above the template limit,
    // empty rectangles from zero real size
    load_setup(32'hFFFF_FFFF, make_size(0, 0), 3'd7, 64'hFFFF_FFFF_FFFF_FFFF,
               '0, '0, '0);
    depth_q = {16'hFFFF, 16'hFFFE, 16'd0};
    play_depths();

    // clamped maximum image, oversized and near full-size patches
    load_setup(32'hFFFF_0000, 22'h3F_FFFF, 3'd4,
               make_patch(4095, 4095, 0, 0, 0, 0),
               make_patch(1, 1, 0, 0, 0, 0),
               make_patch(2000, 2000, 1023, 1023, -1, -1),
               make_patch(800, 800, 0, 0, -300, 100));
    depth_q = {16'd1, 16'hFFFF, 16'd2048, 16'd512, 16'd0};
    play_depths();

    // minimum above maximum, no templates; shrinking the image wraps counters
    load_setup({16'd100, 16'd5000}, make_size(4, 4), 3'd0,
               make_patch(200, 200, 0, 0, 0, 0), '0, '0, '0);
    depth_q = {16'd100, 16'd5000, 16'd2000};
    play_depths();

    while (samples < TOTAL_ITEMS && setups < MAX_SETUPS) begin
      cols  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(4, 40);
      rows  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(3, 24);
      lo    = 16'($urandom_range(100, 800));
      hi    = lo + 16'($urandom_range(200, 3000));
      range_word = ($urandom_range(0, 7) == 0) ? $urandom() : {hi, lo};
      count = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
      for (t = 0; t < NUM_PATCHES; t++) begin
        if ($urandom_range(0, 7) == 0)
          tpls[t] = {$urandom(), $urandom()};
        else
          tpls[t] = make_patch($urandom_range(20, 800), $urandom_range(20, 800),
                               $urandom_range(0, 6), $urandom_range(0, 6),
                               rand_prop(), rand_prop());
      end
      // the long output hold needs a setup that places patches on most pixels
      if (!hold_done) begin
        cols       = 16;
        rows       = 8;
        range_word = {16'd1500, 16'd300};
        count      = 4;
        for (t = 0; t < NUM_PATCHES; t++)
          tpls[t] = make_patch(100 + 100 * t, 150, 0, 0, 0, -64);
      end
      load_setup(range_word, make_size(cols, rows), 3'(count),
                 tpls[0], tpls[1], tpls[2], tpls[3]);

      n = $urandom_range(15, 35);
      if (!hold_done) begin
        long_hold <= 1'b1;
        hold_done = 1'b1;
        n = 40;
      end
      repeat (n) begin
        r = $urandom_range(0, 15);
        if (r == 0)      d = '0;
        else if (r == 1) d = 16'($urandom());
        else             d = 16'($urandom_range(range_word[31:16], range_word[15:0]));
        depth_q.insert(depth_q.size(), d);
      end
      play_depths();
    end

    settle();
    $display("run covered %0d depth samples over %0d register setups, %0d placements checked",
             samples, setups, placements);
    $display("including rejected depths, clamped sizes and counts, and a long output stall");
    if (fail_count == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
